@@ design/bal_pkg.sv @@
package bal_pkg;

    localparam int CAPACITY_DEF   = 256;
    localparam int ELEM_WIDTH_DEF = 32;
    localparam int OP_W           = 3;
    localparam int POS_W          = 8;
    localparam int ENTRY_W        = 32;

    typedef enum logic [OP_W-1:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_TAIL = 3'd1,
        OP_RM_HEAD  = 3'd2,
        OP_RM_TAIL  = 3'd3,
        OP_RM_AT    = 3'd4,
        OP_RD_HEAD  = 3'd5,
        OP_RD_TAIL  = 3'd6,
        OP_RD_AT    = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH_HEAD,
        CELL_PUT_TAIL,
        CELL_PULL_FROM,
        CELL_LANE_LOAD,
        CELL_LANE_SHIFT
    } t_cell_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_HOLD
    } t_state;

endpackage

@@ design/bal_cell.sv @@
module bal_cell #(
    parameter int ELEM_WIDTH = bal_pkg::ELEM_WIDTH_DEF,
    parameter int IW         = 8,
    parameter int INDEX      = 0
) (
    input  logic                   i_clk,
    input  bal_pkg::t_cell_op      i_op,
    input  logic [IW-1:0]          i_idx,
    input  logic [ELEM_WIDTH-1:0]  i_entry,
    input  logic [ELEM_WIDTH-1:0]  i_prev_slot,
    input  logic [ELEM_WIDTH-1:0]  i_next_slot,
    input  logic [ELEM_WIDTH-1:0]  i_next_lane,
    output logic [ELEM_WIDTH-1:0]  o_slot,
    output logic [ELEM_WIDTH-1:0]  o_lane
);

    logic [ELEM_WIDTH-1:0] r_slot;
    logic [ELEM_WIDTH-1:0] n_slot;
    logic [ELEM_WIDTH-1:0] r_lane;
    logic [ELEM_WIDTH-1:0] n_lane;
    logic                  hit;
    logic                  at_or_after;

    assign hit         = (i_idx == IW'(INDEX));
    assign at_or_after = (IW'(INDEX) >= i_idx);

    always_comb begin
        n_slot = r_slot;
        n_lane = r_lane;
        unique case (i_op)
            bal_pkg::CELL_HOLD: begin
            end
            bal_pkg::CELL_PUSH_HEAD: begin
                n_slot = i_prev_slot;
            end
            bal_pkg::CELL_PUT_TAIL: begin
                if (hit) begin
                    n_slot = i_entry;
                end
            end
            bal_pkg::CELL_PULL_FROM: begin
                if (at_or_after) begin
                    n_slot = i_next_slot;
                end
            end
            bal_pkg::CELL_LANE_LOAD: begin
                n_lane = hit ? r_slot : i_next_lane;
            end
            bal_pkg::CELL_LANE_SHIFT: begin
                n_lane = i_next_lane;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_lane <= n_lane;
    end

    assign o_slot = r_slot;
    assign o_lane = r_lane;

endmodule

@@ design/bounded_array_list.sv @@
// channel  | handshake                  | payload
// ---------+----------------------------+----------------------------------
// input    | i_in_valid / o_in_ready    | i_op, i_position, i_entry_in
// output   | o_out_valid / i_out_ready  | o_entry_out, o_count, o_done_ok
//
// inserts and removes update the row in parallel: the cells that move shift or load at once
// reads go down a read lane one cell per cycle, from the cell read to cell 0, then give the result
// reset (i_rst_n low, synchronous) empties the list; cell contents are not cleared
// an output skid register lets one new item in while a result waits;
// a second waiting result holds input off until the output transfer
module bounded_array_list #(
    parameter int CAPACITY   = bal_pkg::CAPACITY_DEF,
    parameter int ELEM_WIDTH = bal_pkg::ELEM_WIDTH_DEF,
    localparam int IW        = $clog2(CAPACITY),
    localparam int CW        = $clog2(CAPACITY + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [bal_pkg::OP_W-1:0]    i_op,
    input  logic [bal_pkg::POS_W-1:0]   i_position,
    input  logic [bal_pkg::ENTRY_W-1:0] i_entry_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [bal_pkg::ENTRY_W-1:0] o_entry_out,
    output logic [CW-1:0]               o_count,
    output logic                        o_done_ok
);

    localparam int PW = (CW > bal_pkg::POS_W) ? CW : bal_pkg::POS_W;

    bal_pkg::t_state            r_state;
    bal_pkg::t_state            n_state;
    logic [CW-1:0]              r_fill;
    logic [CW-1:0]              n_fill;
    logic [IW-1:0]              r_cnt;
    logic [IW-1:0]              n_cnt;

    logic                       r_out_valid;
    logic                       n_out_valid;
    logic [bal_pkg::ENTRY_W-1:0] r_out_entry;
    logic [bal_pkg::ENTRY_W-1:0] n_out_entry;
    logic [CW-1:0]              r_out_count;
    logic [CW-1:0]              n_out_count;
    logic                       r_out_ok;
    logic                       n_out_ok;

    logic [bal_pkg::ENTRY_W-1:0] r_hold_entry;
    logic [bal_pkg::ENTRY_W-1:0] n_hold_entry;
    logic [CW-1:0]              r_hold_count;
    logic [CW-1:0]              n_hold_count;
    logic                       r_hold_ok;
    logic                       n_hold_ok;

    bal_pkg::t_op               op;
    bal_pkg::t_cell_op          cell_op;
    logic [IW-1:0]              cell_idx;
    logic [ELEM_WIDTH-1:0]      entry_val;
    logic                       accept;
    logic                       out_free;
    logic                       not_full;
    logic                       not_empty;
    logic                       pos_in_range;
    logic                       res_valid;
    logic [bal_pkg::ENTRY_W-1:0] res_entry;
    logic [CW-1:0]              res_count;
    logic                       res_ok;

    logic [ELEM_WIDTH-1:0]      w_slot [CAPACITY];
    logic [ELEM_WIDTH-1:0]      w_lane [CAPACITY];

    assign op           = bal_pkg::t_op'(i_op);
    assign entry_val    = ELEM_WIDTH'(i_entry_in);
    assign o_in_ready   = (r_state == bal_pkg::ST_IDLE);
    assign accept       = i_in_valid && o_in_ready;
    assign out_free     = !r_out_valid || i_out_ready;
    assign not_full     = (r_fill != CW'(CAPACITY));
    assign not_empty    = (r_fill != '0);
    assign pos_in_range = (PW'(i_position) < PW'(r_fill));

    // list control and result
    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_cnt     = r_cnt;
        cell_op   = bal_pkg::CELL_HOLD;
        cell_idx  = '0;
        res_valid = 1'b0;
        res_entry = '0;
        res_ok    = 1'b0;
        unique case (r_state)
            bal_pkg::ST_IDLE: begin
                if (accept) begin
                    res_valid = 1'b1;
                    unique case (op)
                        bal_pkg::OP_INS_HEAD: begin
                            if (not_full) begin
                                cell_op = bal_pkg::CELL_PUSH_HEAD;
                                n_fill  = r_fill + CW'(1);
                                res_ok  = 1'b1;
                            end
                        end
                        bal_pkg::OP_INS_TAIL: begin
                            if (not_full) begin
                                cell_op  = bal_pkg::CELL_PUT_TAIL;
                                cell_idx = IW'(r_fill);
                                n_fill   = r_fill + CW'(1);
                                res_ok   = 1'b1;
                            end
                        end
                        bal_pkg::OP_RM_HEAD: begin
                            if (not_empty) begin
                                cell_op = bal_pkg::CELL_PULL_FROM;
                                n_fill  = r_fill - CW'(1);
                                res_ok  = 1'b1;
                            end
                        end
                        bal_pkg::OP_RM_TAIL: begin
                            if (not_empty) begin
                                n_fill = r_fill - CW'(1);
                                res_ok = 1'b1;
                            end
                        end
                        bal_pkg::OP_RM_AT: begin
                            if (pos_in_range) begin
                                cell_op  = bal_pkg::CELL_PULL_FROM;
                                cell_idx = IW'(i_position);
                                n_fill   = r_fill - CW'(1);
                                res_ok   = 1'b1;
                            end
                        end
                        bal_pkg::OP_RD_HEAD: begin
                            if (not_empty) begin
                                cell_op   = bal_pkg::CELL_LANE_LOAD;
                                n_cnt     = '0;
                                n_state   = bal_pkg::ST_READ;
                                res_valid = 1'b0;
                            end
                        end
                        bal_pkg::OP_RD_TAIL: begin
                            if (not_empty) begin
                                cell_op   = bal_pkg::CELL_LANE_LOAD;
                                cell_idx  = IW'(r_fill - CW'(1));
                                n_cnt     = IW'(r_fill - CW'(1));
                                n_state   = bal_pkg::ST_READ;
                                res_valid = 1'b0;
                            end
                        end
                        bal_pkg::OP_RD_AT: begin
                            if (pos_in_range) begin
                                cell_op   = bal_pkg::CELL_LANE_LOAD;
                                cell_idx  = IW'(i_position);
                                n_cnt     = IW'(i_position);
                                n_state   = bal_pkg::ST_READ;
                                res_valid = 1'b0;
                            end
                        end
                    endcase
                end
            end
            bal_pkg::ST_READ: begin
                if (r_cnt == '0) begin
                    res_valid = 1'b1;
                    res_entry = bal_pkg::ENTRY_W'(w_lane[0]);
                    res_ok    = 1'b1;
                    n_state   = bal_pkg::ST_IDLE;
                end else begin
                    cell_op = bal_pkg::CELL_LANE_SHIFT;
                    n_cnt   = r_cnt - IW'(1);
                end
            end
            bal_pkg::ST_HOLD: begin
                if (out_free) begin
                    n_state = bal_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bal_pkg::ST_IDLE;
            end
        endcase
        res_count = n_fill;

        if (res_valid && !out_free) begin
            n_state = bal_pkg::ST_HOLD;
        end
    end

    // output register and skid stage
    always_comb begin
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_entry  = r_out_entry;
        n_out_count  = r_out_count;
        n_out_ok     = r_out_ok;
        n_hold_entry = r_hold_entry;
        n_hold_count = r_hold_count;
        n_hold_ok    = r_hold_ok;
        priority if (r_state == bal_pkg::ST_HOLD && out_free) begin
            n_out_valid = 1'b1;
            n_out_entry = r_hold_entry;
            n_out_count = r_hold_count;
            n_out_ok    = r_hold_ok;
        end else if (res_valid && out_free) begin
            n_out_valid = 1'b1;
            n_out_entry = res_entry;
            n_out_count = res_count;
            n_out_ok    = res_ok;
        end else if (res_valid) begin
            n_hold_entry = res_entry;
            n_hold_count = res_count;
            n_hold_ok    = res_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bal_pkg::ST_IDLE;
            r_fill      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_entry  <= n_out_entry;
        r_out_count  <= n_out_count;
        r_out_ok     <= n_out_ok;
        r_hold_entry <= n_hold_entry;
        r_hold_count <= n_hold_count;
        r_hold_ok    <= n_hold_ok;
    end

    // row of cells, head at index 0
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ELEM_WIDTH-1:0] prev_slot;
        logic [ELEM_WIDTH-1:0] next_slot;
        logic [ELEM_WIDTH-1:0] next_lane;

        if (g == 0) begin : g_head
            assign prev_slot = entry_val;
        end else begin : g_mid
            assign prev_slot = w_slot[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign next_slot = '0;
            assign next_lane = '0;
        end else begin : g_body
            assign next_slot = w_slot[g+1];
            assign next_lane = w_lane[g+1];
        end

        bal_cell #(
            .ELEM_WIDTH (ELEM_WIDTH),
            .IW         (IW),
            .INDEX      (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_op        (cell_op),
            .i_idx       (cell_idx),
            .i_entry     (entry_val),
            .i_prev_slot (prev_slot),
            .i_next_slot (next_slot),
            .i_next_lane (next_lane),
            .o_slot      (w_slot[g]),
            .o_lane      (w_lane[g])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_entry_out = r_out_entry;
    assign o_count     = r_out_count;
    assign o_done_ok   = r_out_ok;

endmodule
